// File: design/fir_pkg.sv
// shared types, constants and crc function of the firmware image receiver
package fir_pkg;

  localparam logic [31:0] MAGIC_WORD  = 32'h5AA5_C33C;
  localparam logic [2:0]  MAGIC_BYTES = 3'd4;
  localparam logic [31:0] CRC_POLY    = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT    = 32'hFFFF_FFFF;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam int OFS_W = 24;
  localparam int CFG_W = 24;

  localparam logic [15:0] IDLE_LIMIT_RST = 16'd2000;
  localparam logic [23:0] MAX_BYTES_RST  = 24'd131072;

  // configuration register indexes
  localparam logic [1:0] REG_IDLE_LIMIT = 2'd0;
  localparam logic [1:0] REG_MAX_BYTES  = 2'd1;

  // input modes
  localparam logic [1:0] MODE_BYTE    = 2'd0;
  localparam logic [1:0] MODE_TICK    = 2'd1;
  localparam logic [1:0] MODE_RESTART = 2'd2;

  // result kinds
  localparam logic [1:0] KIND_WRITE  = 2'd0;
  localparam logic [1:0] KIND_DONE   = 2'd1;
  localparam logic [1:0] KIND_REJECT = 2'd2;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_PAYLOAD,
    PH_ERROR
  } phase_t;

  typedef enum logic [1:0] {
    CMD_WRITE,
    CMD_DONE,
    CMD_REJECT,
    CMD_CLEAR
  } cmd_t;

  typedef struct packed {
    cmd_t               cmd;
    logic               done;
    logic [OFS_W-1:0]   offset;
    logic [7:0]         data;
    logic [OFS_W-1:0]   length;
  } q_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [OFS_W-1:0] offset;
    logic [7:0]       data;
    logic [OFS_W-1:0] length;
    logic [31:0]      crc;
    logic             last;
  } result_t;

  function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// File: design/fir_front.sv
// front part: config registers, header check, payload and idle counting, command issue
module fir_front #(
  parameter int LENGTH_BITS = 24
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [1:0]               in_mode,
  input  logic [7:0]               in_rx_byte,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [1:0]               cfg_index,
  input  logic [fir_pkg::CFG_W-1:0] cfg_wdata,
  input  fir_pkg::q_stat_t         q_stat,
  output logic                     q_push,
  output fir_pkg::q_entry_t        q_wdata
);
  import fir_pkg::*;

  localparam int CW = (LENGTH_BITS > OFS_W) ? LENGTH_BITS : OFS_W;

  phase_t                 phase_r, phase_nxt;
  logic [31:0]            hdr_r, hdr_nxt;
  logic [2:0]             hcnt_r, hcnt_nxt;
  logic [LENGTH_BITS-1:0] pcnt_r, pcnt_nxt;
  logic [15:0]            idle_r, idle_nxt;
  logic [15:0]            idle_limit_r;
  logic [23:0]            max_bytes_r;

  logic                   accept;
  logic [31:0]            hdr_shift;
  logic [2:0]             hcnt_inc;
  logic [LENGTH_BITS-1:0] pcnt_inc;
  logic [15:0]            idle_inc;
  logic                   hdr_full;
  logic                   size_hit;
  logic                   idle_hit;
  logic                   counting;

  assign in_ready  = !q_stat.full;
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;

  assign hdr_shift = {hdr_r[23:0], in_rx_byte};
  assign hcnt_inc  = hcnt_r + 3'd1;
  assign hdr_full  = (hcnt_inc >= MAGIC_BYTES);
  assign pcnt_inc  = pcnt_r + LENGTH_BITS'(1);
  assign size_hit  = (CW'(pcnt_inc) >= CW'(max_bytes_r));
  assign idle_inc  = idle_r + 16'd1;
  assign idle_hit  = (idle_inc >= idle_limit_r);
  assign counting  = (phase_r == PH_PAYLOAD) && (pcnt_r != '0);

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    if (accept) begin
      unique case (in_mode)
        MODE_BYTE: begin
          unique case (phase_r)
            PH_HEADER: begin
              if (hdr_full) begin
                phase_nxt = (hdr_shift == MAGIC_WORD) ? PH_PAYLOAD : PH_ERROR;
              end
            end
            PH_PAYLOAD: begin
              if (size_hit) begin
                phase_nxt = PH_HEADER;
              end
            end
            default: phase_nxt = phase_r;
          endcase
        end
        MODE_TICK: begin
          if (counting && idle_hit) begin
            phase_nxt = PH_HEADER;
          end
        end
        MODE_RESTART: phase_nxt = PH_HEADER;
        default:      phase_nxt = phase_r;
      endcase
    end
  end

  // counters and command issue
  always_comb begin
    hdr_nxt  = hdr_r;
    hcnt_nxt = hcnt_r;
    pcnt_nxt = pcnt_r;
    idle_nxt = idle_r;
    q_push   = 1'b0;
    q_wdata  = '{cmd: CMD_CLEAR, done: 1'b0, offset: '0, data: '0, length: '0};
    if (accept) begin
      unique case (in_mode)
        MODE_BYTE: begin
          idle_nxt = '0;
          unique case (phase_r)
            PH_HEADER: begin
              hdr_nxt  = hdr_shift;
              hcnt_nxt = hcnt_inc;
              if (hdr_full && (hdr_shift != MAGIC_WORD)) begin
                q_push      = 1'b1;
                q_wdata.cmd = CMD_REJECT;
              end
            end
            PH_PAYLOAD: begin
              q_push         = 1'b1;
              q_wdata.cmd    = CMD_WRITE;
              q_wdata.offset = OFS_W'(pcnt_r);
              q_wdata.data   = in_rx_byte;
              q_wdata.length = OFS_W'(pcnt_inc);
              q_wdata.done   = size_hit;
              pcnt_nxt       = pcnt_inc;
              if (size_hit) begin
                hdr_nxt  = '0;
                hcnt_nxt = '0;
                pcnt_nxt = '0;
              end
            end
            default: idle_nxt = '0;
          endcase
        end
        MODE_TICK: begin
          if (counting) begin
            idle_nxt = idle_inc;
            if (idle_hit) begin
              q_push         = 1'b1;
              q_wdata.cmd    = CMD_DONE;
              q_wdata.length = OFS_W'(pcnt_r);
              hdr_nxt        = '0;
              hcnt_nxt       = '0;
              pcnt_nxt       = '0;
              idle_nxt       = '0;
            end
          end else begin
            idle_nxt = '0;
          end
        end
        MODE_RESTART: begin
          q_push      = 1'b1;
          q_wdata.cmd = CMD_CLEAR;
          hdr_nxt     = '0;
          hcnt_nxt    = '0;
          pcnt_nxt    = '0;
          idle_nxt    = '0;
        end
        default: idle_nxt = idle_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_HEADER;
      hdr_r        <= '0;
      hcnt_r       <= '0;
      pcnt_r       <= '0;
      idle_r       <= '0;
      idle_limit_r <= IDLE_LIMIT_RST;
      max_bytes_r  <= MAX_BYTES_RST;
    end else begin
      phase_r <= phase_nxt;
      hdr_r   <= hdr_nxt;
      hcnt_r  <= hcnt_nxt;
      pcnt_r  <= pcnt_nxt;
      idle_r  <= idle_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_IDLE_LIMIT: idle_limit_r <= cfg_wdata[15:0];
          REG_MAX_BYTES:  max_bytes_r  <= cfg_wdata[23:0];
          default:        idle_limit_r <= idle_limit_r;
        endcase
      end
    end
  end

endmodule

// File: design/fir_fifo.sv
// short command queue between front and back
module fir_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  fir_pkg::q_entry_t wdata,
  input  logic              pop,
  output fir_pkg::q_entry_t rdata,
  output fir_pkg::q_stat_t  stat
);
  import fir_pkg::*;

  q_entry_t          mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QPTR_W:0]   count_r;
  logic              do_push;
  logic              do_pop;

  assign stat.full  = (count_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign stat.empty = (count_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign rdata      = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + (QPTR_W+1)'(1);
        2'b01:   count_r <= count_r - (QPTR_W+1)'(1);
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

// File: design/fir_back.sv
// back part: crc accumulation and result output register
module fir_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  fir_pkg::q_entry_t           q_rdata,
  input  fir_pkg::q_stat_t            q_stat,
  output logic                        q_pop,
  output logic                        out_valid,
  input  logic                        out_ready,
  output fir_pkg::result_t            out_res
);
  import fir_pkg::*;

  logic             valid_r, valid_nxt;
  result_t          res_r, res_nxt;
  logic [31:0]      crc_r, crc_nxt;
  logic             pend_r, pend_nxt;
  logic [OFS_W-1:0] pend_len_r, pend_len_nxt;
  logic             take;

  assign take      = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_res   = res_r;

  always_comb begin
    valid_nxt    = valid_r;
    res_nxt      = res_r;
    crc_nxt      = crc_r;
    pend_nxt     = pend_r;
    pend_len_nxt = pend_len_r;
    q_pop        = 1'b0;
    if (take) begin
      valid_nxt = 1'b0;
      if (pend_r) begin
        valid_nxt = 1'b1;
        res_nxt   = '{kind: KIND_DONE, offset: '0, data: '0, length: pend_len_r,
                      crc: ~crc_r, last: 1'b1};
        crc_nxt   = CRC_INIT;
        pend_nxt  = 1'b0;
      end else if (!q_stat.empty) begin
        q_pop = 1'b1;
        unique case (q_rdata.cmd)
          CMD_WRITE: begin
            valid_nxt    = 1'b1;
            res_nxt      = '{kind: KIND_WRITE, offset: q_rdata.offset, data: q_rdata.data,
                             length: '0, crc: '0, last: !q_rdata.done};
            crc_nxt      = crc32_byte(crc_r, q_rdata.data);
            pend_nxt     = q_rdata.done;
            pend_len_nxt = q_rdata.length;
          end
          CMD_DONE: begin
            valid_nxt = 1'b1;
            res_nxt   = '{kind: KIND_DONE, offset: '0, data: '0, length: q_rdata.length,
                          crc: ~crc_r, last: 1'b1};
            crc_nxt   = CRC_INIT;
          end
          CMD_REJECT: begin
            valid_nxt = 1'b1;
            res_nxt   = '{kind: KIND_REJECT, offset: '0, data: '0, length: '0,
                          crc: '0, last: 1'b1};
          end
          CMD_CLEAR: begin
            crc_nxt = CRC_INIT;
          end
          default: crc_nxt = crc_r;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      crc_r   <= CRC_INIT;
      pend_r  <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      crc_r   <= crc_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r      <= res_nxt;
    pend_len_r <= pend_len_nxt;
  end

endmodule

// File: design/firmware_image_receiver.sv
// top level of the firmware image receiver: front, command queue, back
//
//   channel  direction  handshake             payload
//   in       input      in_valid/in_ready     in_mode, in_rx_byte
//   out      output     out_valid/out_ready   out_event_kind .. out_last
//   cfg      input      cfg_valid/cfg_ready   cfg_index, cfg_wdata
//
// one input word per cycle while the command queue is not full; a payload byte
// that ends the image gives a write word, then a completion word, from the single
// output register of the back part; an accepted word passes the command queue first
// in_ready drops only when the four-entry queue is full; cfg_ready is always high
// synchronous active-low reset restores register defaults and waits for a header
module firmware_image_receiver #(
  parameter int LENGTH_BITS = 24
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_mode,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_event_kind,
  output logic [23:0] out_byte_offset,
  output logic [7:0]  out_write_byte,
  output logic [23:0] out_image_length,
  output logic [31:0] out_image_crc,
  output logic        out_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_wdata
);
  import fir_pkg::*;

  q_stat_t  q_stat;
  q_entry_t q_wdata;
  q_entry_t q_rdata;
  logic     q_push;
  logic     q_pop;
  result_t  res;

  fir_front #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_mode   (in_mode),
    .in_rx_byte(in_rx_byte),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .q_stat    (q_stat),
    .q_push    (q_push),
    .q_wdata   (q_wdata)
  );

  fir_fifo u_fifo (
    .clk  (clk),
    .rst_n(rst_n),
    .push (q_push),
    .wdata(q_wdata),
    .pop  (q_pop),
    .rdata(q_rdata),
    .stat (q_stat)
  );

  fir_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_rdata  (q_rdata),
    .q_stat   (q_stat),
    .q_pop    (q_pop),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_res  (res)
  );

  assign out_event_kind   = res.kind;
  assign out_byte_offset  = res.offset;
  assign out_write_byte   = res.data;
  assign out_image_length = res.length;
  assign out_image_crc    = res.crc;
  assign out_last         = res.last;

  a_reject_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_event_kind == KIND_REJECT) |-> out_last)
    else $error("reject word without last");

  a_write_then_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && (out_event_kind == KIND_WRITE) && !out_last
    |=> out_valid && (out_event_kind == KIND_DONE) && out_last)
    else $error("final write not followed by completion");

  a_queue_stat: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_stat.full && q_stat.empty))
    else $error("queue full and empty at once");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_stat.full)
    else $error("command issued into full queue");

endmodule

// File: test/image_check_pkg.sv
// scoreboard class holding the image receiver predictor and the result checks
package image_check_pkg;
  import fir_pkg::*;

  localparam logic [1:0] MODE_NONE = 2'd3;

  class image_scoreboard;
    result_t     expected_events[$];
    phase_t      stage;
    logic [31:0] magic_acc;
    logic [2:0]  magic_cnt;
    logic [23:0] image_cnt;
    logic [31:0] crc_acc;
    logic [15:0] quiet_ticks;
    logic [15:0] tick_limit;
    logic [23:0] size_limit;
    int unsigned failures;
    int unsigned results_seen;
    int unsigned writes_seen;
    int unsigned images_done;
    int unsigned headers_rejected;

    function new();
      tick_limit       = IDLE_LIMIT_RST;
      size_limit       = MAX_BYTES_RST;
      failures         = 0;
      results_seen     = 0;
      writes_seen      = 0;
      images_done      = 0;
      headers_rejected = 0;
      restart_image();
    endfunction

    function void restart_image();
      stage       = PH_HEADER;
      magic_acc   = '0;
      magic_cnt   = '0;
      image_cnt   = '0;
      crc_acc     = CRC_INIT;
      quiet_ticks = '0;
    endfunction

    function void flag(string msg);
      failures++;
      if (failures <= 10) $display("tb_top: %s", msg);
    endfunction

    // reflected crc-32, one data bit at a time
    function logic [31:0] fold_byte(logic [31:0] c, logic [7:0] b);
      for (int k = 0; k < 8; k++) begin
        if (c[0] ^ b[k]) c = (c >> 1) ^ CRC_POLY;
        else c = c >> 1;
      end
      return c;
    endfunction

    function result_t close_image();
      result_t r;
      r        = '0;
      r.kind   = KIND_DONE;
      r.length = image_cnt;
      r.crc    = ~crc_acc;
      restart_image();
      return r;
    endfunction

    function void write_reg(logic [1:0] idx, logic [23:0] value);
      if (idx == REG_IDLE_LIMIT) tick_limit = value[15:0];
      else if (idx == REG_MAX_BYTES) size_limit = value;
    endfunction

    function void predict_word(logic [1:0] mode, logic [7:0] data);
      result_t ev[$];
      result_t r;
      r = '0;
      case (mode)
        MODE_RESTART: restart_image();
        MODE_BYTE: begin
          quiet_ticks = '0;
          if (stage == PH_HEADER) begin
            magic_acc = {magic_acc[23:0], data};
            magic_cnt = magic_cnt + 3'd1;
            if (magic_cnt >= MAGIC_BYTES) begin
              if (magic_acc == MAGIC_WORD) begin
                stage = PH_PAYLOAD;
              end else begin
                stage  = PH_ERROR;
                r.kind = KIND_REJECT;
                ev.push_back(r);
              end
            end
          end else if (stage == PH_PAYLOAD) begin
            r.kind   = KIND_WRITE;
            r.offset = image_cnt;
            r.data   = data;
            ev.push_back(r);
            crc_acc   = fold_byte(crc_acc, data);
            image_cnt = image_cnt + 24'd1;
            if (image_cnt >= size_limit) ev.push_back(close_image());
          end
        end
        MODE_TICK: begin
          if (stage == PH_PAYLOAD && image_cnt != 0) begin
            quiet_ticks = quiet_ticks + 16'd1;
            if (quiet_ticks >= tick_limit) ev.push_back(close_image());
          end else begin
            quiet_ticks = '0;
          end
        end
        default: ;
      endcase
      if (ev.size() > 0) ev[ev.size() - 1].last = 1'b1;
      foreach (ev[i]) expected_events.push_back(ev[i]);
    endfunction

    function void check_word(result_t got);
      result_t want;
      results_seen++;
      if (expected_events.size() == 0) begin
        flag($sformatf("unexpected result kind %0d ofs %06h byte %02h len %0d crc %08h last %0b",
                       got.kind, got.offset, got.data, got.length, got.crc, got.last));
        return;
      end
      want = expected_events.pop_front();
      if (got.kind !== want.kind || got.offset !== want.offset || got.data !== want.data ||
          got.length !== want.length || got.crc !== want.crc || got.last !== want.last) begin
        flag($sformatf({"mismatch: expected kind %0d ofs %06h byte %02h len %0d crc %08h last %0b,",
                        " got kind %0d ofs %06h byte %02h len %0d crc %08h last %0b"},
                       want.kind, want.offset, want.data, want.length, want.crc, want.last,
                       got.kind, got.offset, got.data, got.length, got.crc, got.last));
      end
      case (want.kind)
        KIND_WRITE:  writes_seen++;
        KIND_DONE:   images_done++;
        KIND_REJECT: headers_rejected++;
        default: ;
      endcase
    endfunction

    function void leftover_check();
      if (expected_events.size() != 0)
        flag($sformatf("%0d expected results never arrived", expected_events.size()));
    endfunction
  endclass

endpackage

// File: test/tb_top.sv
// top-level testbench of the firmware image receiver
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import fir_pkg::*;
  import image_check_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 2000000;
  localparam int unsigned WORD_TARGET = 1500;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_mode;
  logic [7:0]  in_rx_byte;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  out_event_kind;
  logic [23:0] out_byte_offset;
  logic [7:0]  out_write_byte;
  logic [23:0] out_image_length;
  logic [31:0] out_image_crc;
  logic        out_last;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [23:0] cfg_wdata;

  image_scoreboard sb = new();
  int unsigned     cycles = 0;
  int unsigned     words_sent = 0;
  int unsigned     settings_used = 0;
  bit              steady = 1'b0;
  logic [15:0]     cur_idle;
  logic [23:0]     cur_size;

  firmware_image_receiver dut (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb_top: timeout after %0d cycles", cycles);
      $display("tb_top: FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_word({out_event_kind, out_byte_offset, out_write_byte,
                     out_image_length, out_image_crc, out_last});
  end

  function automatic int unsigned draw_pause();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  initial begin : sink
    int unsigned hold;
    hold      = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        out_ready <= 1'b0;
        hold--;
      end else begin
        out_ready <= 1'b1;
        if (!steady && $urandom_range(0, 99) < 30) hold = draw_pause();
      end
    end
  end

  // called at a falling edge, returns at a falling edge with valid still high
  task automatic send_word(input logic [1:0] mode, input logic [7:0] data);
    int unsigned gap;
    gap = (steady || $urandom_range(0, 99) < 55) ? 0 : draw_pause();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_mode    <= mode;
    in_rx_byte <= data;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.predict_word(mode, data);
    if (mode != MODE_NONE) words_sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (sb.expected_events.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic apply_limits(input logic [15:0] idle, input logic [23:0] size);
    bit          size_first;
    logic [1:0]  idx;
    logic [23:0] value;
    size_first = 1'($urandom_range(0, 1));
    drain();
    for (int k = 0; k < 2; k++) begin
      idx       = ((k == 0) ^ size_first) ? REG_IDLE_LIMIT : REG_MAX_BYTES;
      value     = (idx == REG_IDLE_LIMIT) ? {8'd0, idle} : size;
      cfg_valid <= 1'b1;
      cfg_index <= idx;
      cfg_wdata <= value;
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      sb.write_reg(idx, value);
      @(negedge clk);
    end
    cfg_valid <= 1'b0;
    cur_idle  = idle;
    cur_size  = size;
    settings_used++;
  endtask

  // header bytes, one of them corrupted when bad_at is below four
  task automatic send_magic(input int unsigned bad_at, input bit with_ticks);
    logic [7:0] b;
    for (int i = 0; i < 4; i++) begin
      b = 8'(MAGIC_WORD >> (8 * (3 - i)));
      if (i == bad_at) b = b ^ (8'd1 << $urandom_range(0, 7));
      if (with_ticks && $urandom_range(0, 9) == 0) send_word(MODE_TICK, 8'($urandom));
      send_word(MODE_BYTE, b);
    end
  endtask

  task automatic send_image(input bit broken);
    int unsigned n_bytes;
    int unsigned run;
    send_magic(broken ? $urandom_range(0, 3) : 4, 1'b1);
    if (broken) begin
      repeat ($urandom_range(0, 3))
        send_word($urandom_range(0, 1) ? MODE_BYTE : MODE_TICK, 8'($urandom));
      send_word(MODE_RESTART, 8'($urandom));
      return;
    end
    n_bytes = $urandom_range(1, (cur_size == 0) ? 1 : ((cur_size > 40) ? 40 : cur_size));
    for (int i = 0; i < n_bytes; i++) begin
      if (i > 0 && cur_idle > 1 && $urandom_range(0, 6) == 0) begin
        run = $urandom_range(1, (cur_idle > 10) ? 10 : cur_idle - 1);
        repeat (run) send_word(MODE_TICK, 8'($urandom));
      end
      send_word(MODE_BYTE, 8'($urandom));
    end
    if (n_bytes >= cur_size) return;
    if (cur_idle <= 16 && $urandom_range(0, 4) != 0)
      repeat ((cur_idle == 0) ? 1 : cur_idle) send_word(MODE_TICK, 8'($urandom));
    else
      send_word(MODE_RESTART, 8'($urandom));
  endtask

  initial begin : stimulus
    int unsigned phase_end;
    int unsigned r;
    logic [15:0] idle;
    logic [23:0] size;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_mode    = MODE_BYTE;
    in_rx_byte = 8'd0;
    cfg_valid  = 1'b0;
    cfg_index  = REG_IDLE_LIMIT;
    cfg_wdata  = 24'd0;
    cur_idle   = IDLE_LIMIT_RST;
    cur_size   = MAX_BYTES_RST;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    repeat (2) @(negedge clk);

    // reset limits: bad header, error lockout, restart, good header, payload
    send_word(MODE_TICK, 8'h00);
    send_word(MODE_BYTE, 8'h5A);
    send_word(MODE_NONE, 8'hFF);
    send_word(MODE_BYTE, 8'hA5);
    send_word(MODE_BYTE, 8'hC3);
    send_word(MODE_BYTE, 8'h00);
    send_word(MODE_BYTE, 8'hFF);
    send_word(MODE_TICK, 8'hFF);
    send_word(MODE_RESTART, 8'h00);
    send_magic(4, 1'b0);
    send_word(MODE_BYTE, 8'h00);
    send_word(MODE_BYTE, 8'hFF);
    send_word(MODE_TICK, 8'h00);
    apply_limits(16'd1, 24'd1);
    send_word(MODE_TICK, 8'h00);
    apply_limits(16'd0, 24'd0);
    send_magic(4, 1'b0);
    send_word(MODE_BYTE, 8'hA5);
    apply_limits(16'hFFFF, 24'hFFFFFF);
    send_magic(4, 1'b0);
    send_word(MODE_BYTE, 8'h3C);
    send_word(MODE_TICK, 8'h00);
    send_word(MODE_RESTART, 8'h00);

    while (words_sent < WORD_TARGET) begin
      r    = $urandom_range(0, 99);
      idle = (r < 10) ? 16'd0 : (r < 18) ? 16'hFFFF :
             (r < 28) ? 16'd1 : 16'($urandom_range(2, 12));
      r    = $urandom_range(0, 99);
      size = (r < 10) ? 24'd0 : (r < 18) ? 24'hFFFFFF :
             (r < 28) ? 24'd1 : 24'($urandom_range(2, 40));
      apply_limits(idle, size);
      steady    = ($urandom_range(0, 4) == 0);
      phase_end = words_sent + $urandom_range(80, 120);
      while (words_sent < phase_end) begin
        r = $urandom_range(0, 99);
        if (r < 75) begin
          send_image(1'b0);
        end else if (r < 85) begin
          send_image(1'b1);
        end else if (r < 97) begin
          repeat ($urandom_range(1, 6)) send_word(2'($urandom), 8'($urandom));
          if ($urandom_range(0, 1)) send_word(MODE_RESTART, 8'($urandom));
        end else begin
          drain();
        end
      end
    end

    steady = 1'b0;
    drain();
    repeat (12) @(negedge clk);
    sb.leftover_check();
    $display("tb_top: %0d input words over %0d limit settings, %0d results checked",
             words_sent, settings_used, sb.results_seen);
    $display("tb_top: %0d byte writes, %0d images completed, %0d headers rejected, %0d failures",
             sb.writes_seen, sb.images_done, sb.headers_rejected, sb.failures);
    if (sb.failures == 0) $display("tb_top: PASS");
    else $display("tb_top: FAIL");
    $finish;
  end

endmodule

// File: firmware_image_receiver.f
design/fir_pkg.sv
design/fir_front.sv
design/fir_fifo.sv
design/fir_back.sv
design/firmware_image_receiver.sv
test/image_check_pkg.sv
test/tb_top.sv
